// ===== src/sdpq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpq_pkg
// Shared types and constants for the sorted date priority queue.
// ----------------------------------------------------------------------------
package sdpq_pkg;

	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int KEY_W   = MONTH_W + DAY_W;
	localparam int FILL_W  = 5;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

// ===== src/sdpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdpq_ctrl
// Request sequencer: accepts an item, runs one update step and holds the
// result valid until it is taken.
// ----------------------------------------------------------------------------
module sdpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output sdpq_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		CS_WAIT = 2'b01,
		CS_EXEC = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        accept;

	assign s_tready = (state_q == CS_WAIT) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	assign cmd.load = accept;
	assign cmd.exec = (state_q == CS_EXEC);

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_WAIT: begin
				if (accept) state_d = CS_EXEC;
			end
			CS_EXEC: begin
				state_d = CS_WAIT;
			end
			default: begin
				state_d = CS_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/sdpq_datapath.sv =====
// ----------------------------------------------------------------------------
// sdpq_datapath
// Sorted shift-register cells with parallel compare, entry count and
// result registers.
// ----------------------------------------------------------------------------
module sdpq_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sdpq_pkg::dp_cmd_t              cmd,
	input  logic                           in_req_type,
	input  logic [sdpq_pkg::MONTH_W-1:0]   in_month,
	input  logic [sdpq_pkg::DAY_W-1:0]     in_day,
	output sdpq_pkg::status_t              res_status,
	output logic [sdpq_pkg::MONTH_W-1:0]   res_month,
	output logic [sdpq_pkg::DAY_W-1:0]     res_day,
	output logic [sdpq_pkg::FILL_W-1:0]    res_fill
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int KW    = sdpq_pkg::KEY_W;

	logic [KW-1:0]    cell_q [QUEUE_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             req_q;
	logic [KW-1:0]    key_q;
	logic             empty;
	logic             full;
	logic             do_enq;
	logic             do_deq;
	logic [QUEUE_DEPTH-1:0] gt;
	logic [QUEUE_DEPTH-1:0] at_end;

	sdpq_pkg::status_t                 status_q;
	logic [sdpq_pkg::MONTH_W-1:0]      month_q;
	logic [sdpq_pkg::DAY_W-1:0]        day_q;
	logic [sdpq_pkg::FILL_W-1:0]       fill_q;

	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_enq = cmd.exec && (req_q == sdpq_pkg::REQ_ENQ) && !full;
	assign do_deq = cmd.exec && (req_q == sdpq_pkg::REQ_DEQ) && !empty;

	// per-cell compare against the new key
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cmp
		assign gt[i]     = (CNT_W'(i) < count_q) && (cell_q[i] > key_q);
		assign at_end[i] = (CNT_W'(i) == count_q);
	end

	always_comb begin
		count_d = count_q;
		if (do_enq) count_d = count_q + CNT_W'(1);
		else if (do_deq) count_d = count_q - CNT_W'(1);
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_req_type;
			key_q <= {in_month, in_day};
		end
	end

	// cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_enq) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || at_end[i]) begin
					cell_q[i] <= key_q;
				end
			end else if (do_deq) begin
				if (i < QUEUE_DEPTH - 1) begin
					cell_q[i] <= cell_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= sdpq_pkg::STATUS_OK;
			month_q  <= '0;
			day_q    <= '0;
			fill_q   <= sdpq_pkg::FILL_W'(count_d);
			if (req_q == sdpq_pkg::REQ_ENQ) begin
				if (full) status_q <= sdpq_pkg::STATUS_FULL;
			end else if (empty) begin
				status_q <= sdpq_pkg::STATUS_EMPTY;
			end else begin
				month_q <= cell_q[0][KW-1:sdpq_pkg::DAY_W];
				day_q   <= cell_q[0][sdpq_pkg::DAY_W-1:0];
			end
		end
	end

	assign res_status = status_q;
	assign res_month  = month_q;
	assign res_day    = day_q;
	assign res_fill   = fill_q;

endmodule

// ===== src/sorted_date_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_date_priority_queue_core
// Bounded priority queue of (month, day) keys kept in ascending order.
// ----------------------------------------------------------------------------
// an accepted item moves the sequencer to its update step, which loads the result
// registers; no item is accepted during that step or while a result waits on m_tready
// the update step compares all cells in parallel and shifts them together
// reset: asynchronous, clears the entry count and handshake state
// cell contents are undefined after reset and never read before written
// ----------------------------------------------------------------------------
module sorted_date_priority_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // in_month[3:0], in_day[8:4], zero[15:9]
	input  logic [0:0]  s_tuser,  // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_month[3:0], out_day[8:4], fill_count[13:9], zero[15:14]
	output logic [1:0]  m_tuser   // status[1:0]
);

	sdpq_pkg::dp_cmd_t              cmd;
	sdpq_pkg::status_t              res_status;
	logic [sdpq_pkg::MONTH_W-1:0]   res_month;
	logic [sdpq_pkg::DAY_W-1:0]     res_day;
	logic [sdpq_pkg::FILL_W-1:0]    res_fill;

	sdpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	sdpq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_req_type (s_tuser[0]),
		.in_month    (s_tdata[3:0]),
		.in_day      (s_tdata[8:4]),
		.res_status  (res_status),
		.res_month   (res_month),
		.res_day     (res_day),
		.res_fill    (res_fill)
	);

	assign m_tdata = {2'b00, res_fill, res_day, res_month};
	assign m_tuser = res_status;

	a_exec_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !m_tvalid)
		else $error("update step while a result is still pending");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##2 m_tvalid)
		else $error("accepted item produced no result");

	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !s_tready)
		else $error("item accepted during update step");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_date_priority_queue_core. A local sorted-key
// predictor tracks every accepted request and the results are checked in
// order, field by field. Directed fill, full and empty cases come first,
// followed by random traffic phases with bursty input, receiver stalls and a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDLE_LIMIT  = 5000;
	localparam int EXP_DEPTH   = 256;

	typedef struct packed {
		sdpq_pkg::status_t                status;
		logic [sdpq_pkg::MONTH_W-1:0]     month;
		logic [sdpq_pkg::DAY_W-1:0]       day;
		logic [sdpq_pkg::FILL_W-1:0]      fill;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	sorted_date_priority_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// predicted queue contents, ascending
	logic [sdpq_pkg::KEY_W-1:0] held_keys [QUEUE_DEPTH];
	int                         held_count = 0;

	// expected results in order of acceptance
	queue_result_t expect_buf [EXP_DEPTH];
	int            exp_wr = 0;
	int            exp_rd = 0;

	int fail_count = 0;
	int burst_left = 0;
	int gap_max = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	function automatic queue_result_t next_queue_result(sdpq_pkg::req_t req,
			logic [sdpq_pkg::MONTH_W-1:0] month, logic [sdpq_pkg::DAY_W-1:0] day);
		queue_result_t              res;
		logic [sdpq_pkg::KEY_W-1:0] key;
		int                         pos;
		res = '{status: sdpq_pkg::STATUS_OK, month: '0, day: '0, fill: '0};
		key = {month, day};
		if (req == sdpq_pkg::REQ_ENQ) begin
			if (held_count >= QUEUE_DEPTH) begin
				res.status = sdpq_pkg::STATUS_FULL;
			end else begin
				pos = 0;
				// equal keys stay in arrival order
				while (pos < held_count && held_keys[pos] <= key)
					pos++;
				for (int i = held_count; i > pos; i--)
					held_keys[i] = held_keys[i-1];
				held_keys[pos] = key;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				res.status = sdpq_pkg::STATUS_EMPTY;
			end else begin
				res.month = held_keys[0][sdpq_pkg::KEY_W-1:sdpq_pkg::DAY_W];
				res.day   = held_keys[0][sdpq_pkg::DAY_W-1:0];
				for (int i = 1; i < held_count; i++)
					held_keys[i-1] = held_keys[i];
				held_count--;
			end
		end
		res.fill = held_count[sdpq_pkg::FILL_W-1:0];
		return res;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// one item, held until accepted, then a gap when the burst runs out and gaps are enabled
	task automatic push_request(sdpq_pkg::req_t req, logic [sdpq_pkg::MONTH_W-1:0] month,
			logic [sdpq_pkg::DAY_W-1:0] day);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, day, month};
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
		expect_buf[exp_wr[7:0]] = next_queue_result(req, month, day);
		exp_wr++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (exp_wr != exp_rd);
	endtask

	task automatic random_request(int enq_pct);
		sdpq_pkg::req_t               req;
		logic [sdpq_pkg::MONTH_W-1:0] month;
		logic [sdpq_pkg::DAY_W-1:0]   day;
		req = ($urandom_range(0, 99) < enq_pct) ? sdpq_pkg::REQ_ENQ : sdpq_pkg::REQ_DEQ;
		if ($urandom_range(0, 3) == 0)
			month = $urandom_range(0, 1) ? 4'd15 : 4'd0;
		else
			month = sdpq_pkg::MONTH_W'($urandom_range(0, 15));
		if ($urandom_range(0, 3) == 0)
			day = $urandom_range(0, 1) ? 5'd31 : 5'd0;
		else
			day = sdpq_pkg::DAY_W'($urandom_range(0, 31));
		push_request(req, month, day);
	endtask

	task automatic run_random_phase(int count, int enq_pct, int stall, int gaps);
		stall_pct = stall;
		gap_max = gaps;
		for (int i = 0; i < count; i++)
			random_request(enq_pct);
		drain_results();
	endtask

	task automatic test_empty_dequeue();
		gap_max = 3;
		stall_pct = 20;
		push_request(sdpq_pkg::REQ_DEQ, 4'd15, 5'd31);
		push_request(sdpq_pkg::REQ_DEQ, 4'd0, 5'd0);
		drain_results();
	endtask

	task automatic test_fill_to_full();
		logic [sdpq_pkg::MONTH_W-1:0] month;
		logic [sdpq_pkg::DAY_W-1:0]   day;
		gap_max = 3;
		stall_pct = 20;
		push_request(sdpq_pkg::REQ_ENQ, 4'd15, 5'd31);
		push_request(sdpq_pkg::REQ_ENQ, 4'd0, 5'd0);
		push_request(sdpq_pkg::REQ_ENQ, 4'd0, 5'd31);
		push_request(sdpq_pkg::REQ_ENQ, 4'd15, 5'd0);
		// duplicates of one key
		push_request(sdpq_pkg::REQ_ENQ, 4'd7, 5'd12);
		push_request(sdpq_pkg::REQ_ENQ, 4'd7, 5'd12);
		push_request(sdpq_pkg::REQ_ENQ, 4'd7, 5'd12);
		for (int i = 0; i < QUEUE_DEPTH - 7; i++) begin
			month = sdpq_pkg::MONTH_W'($urandom_range(0, 15));
			day = sdpq_pkg::DAY_W'($urandom_range(0, 31));
			push_request(sdpq_pkg::REQ_ENQ, month, day);
		end
		push_request(sdpq_pkg::REQ_ENQ, 4'd1, 5'd1);
		push_request(sdpq_pkg::REQ_ENQ, 4'd0, 5'd0);
		for (int i = 0; i < 4; i++)
			push_request(sdpq_pkg::REQ_DEQ, 4'd0, 5'd0);
		drain_results();
	endtask

	task automatic test_mixed_traffic();
		run_random_phase(600, 50, 30, 6);
	endtask

	task automatic test_full_pressure();
		run_random_phase(450, 80, 10, 2);
	endtask

	task automatic test_empty_pressure();
		run_random_phase(450, 25, 40, 4);
	endtask

	task automatic test_no_idle();
		run_random_phase(250, 50, 0, 0);
	endtask

	task automatic test_receiver_holdoff();
		stall_pct = 0;
		gap_max = 0;
		hold_req = 300;
		for (int i = 0; i < 40; i++)
			random_request(60);
		drain_results();
		run_random_phase(160, 50, 70, 3);
	endtask

	// receiver: random stalls, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		queue_result_t want;
		if (m_tvalid && m_tready) begin
			if (exp_wr == exp_rd) begin
				flag_mismatch("unexpected result item", 1, 0);
			end else begin
				want = expect_buf[exp_rd[7:0]];
				exp_rd++;
				if (m_tuser !== want.status)
					flag_mismatch("status", m_tuser, want.status);
				if (m_tdata[3:0] !== want.month)
					flag_mismatch("out_month", m_tdata[3:0], want.month);
				if (m_tdata[8:4] !== want.day)
					flag_mismatch("out_day", m_tdata[8:4], want.day);
				if (m_tdata[13:9] !== want.fill)
					flag_mismatch("fill_count", m_tdata[13:9], want.fill);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_dequeue();
		test_fill_to_full();
		test_mixed_traffic();
		test_full_pressure();
		test_empty_pressure();
		test_no_idle();
		test_receiver_holdoff();
		repeat (20) @(posedge clk);
		if (exp_wr != exp_rd)
			flag_mismatch("result items never arrived", 0, exp_wr - exp_rd);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
